@@ design/hqs_pkg.sv @@
package hqs_pkg;
   localparam int Capacity  = 1024;
   localparam int AddrWidth = 10;
   localparam int CountWidth = 11;
   localparam int StackDepth = 16;
   localparam int SpWidth   = 4;

   typedef enum logic [1:0] {
      CMD_LOAD  = 2'd0,
      CMD_SORT  = 2'd1,
      CMD_READ  = 2'd2,
      CMD_CLEAR = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_FULL = 2'd1,
      ST_OOR  = 2'd2
   } status_type;

   typedef logic [AddrWidth-1:0] addr_type;
endpackage

@@ design/hoare_quicksort_engine.sv @@
// Sorting store of up to 1024 signed 32-bit values. Load and clear answer in
// the cycle after the transaction is accepted. A read answer first passes
// through the registered read of the element memory, and a read holds
// req_tready low while it is pending. A result waiting in the output
// register does not hold the input back if it is taken in the same cycle.
// Sort holds req_tready low while a sequencer walks the element memory (one
// write port and one registered read port) running Hoare partitions around
// the middle element, with an explicit range stack in a small RAM. Each
// element visited by either scan takes a read state and a check state, and
// each swap adds the swap state. Each range also passes the pivot read, the
// split and the stack pop. A sort of fewer than two elements answers in the
// following cycle.
module hoare_quicksort_engine
   import hqs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // cmd[1:0], value[33:2], index[43:34], zeros [47:44]
   input  logic [47:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // data[31:0], status[33:32], count[44:34], zeros [47:45]
   output logic [47:0] rsp_tdata
);
   typedef enum logic [10:0] {
      S_IDLE  = 11'b00000000001,
      S_PIVRD = 11'b00000000010,
      S_PIVWT = 11'b00000000100,
      S_FRD   = 11'b00000001000,
      S_FCHK  = 11'b00000010000,
      S_LRD   = 11'b00000100000,
      S_LCHK  = 11'b00001000000,
      S_SWAP  = 11'b00010000000,
      S_SPLIT = 11'b00100000000,
      S_POPRD = 11'b01000000000,
      S_POPWT = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic [SpWidth-1:0] sp_ff, sp_in;
   addr_type lo_ff, lo_in, hi_ff, hi_in, f_ff, f_in, l_ff, l_in;
   logic signed [31:0] pivot_ff, pivot_in, fval_ff, fval_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_data_ff, rsp_data_in;
   logic [1:0] rsp_status_ff, rsp_status_in;
   logic rd_pending_ff, rd_pending_in;

   logic mem_we;
   addr_type mem_waddr, mem_raddr;
   logic [31:0] mem_wdata, mem_rdata;
   logic stk_we;
   logic [SpWidth-1:0] stk_waddr, stk_raddr;
   logic [2*AddrWidth-1:0] stk_wdata, stk_rdata;

   hqs_ram #(.Width(32), .Depth(Capacity)) u_store (
      .clock(clock), .wr_en(mem_we), .wr_addr(mem_waddr), .wr_data(mem_wdata),
      .rd_addr(mem_raddr), .rd_data(mem_rdata));

   hqs_ram #(.Width(2*AddrWidth), .Depth(StackDepth)) u_stack (
      .clock(clock), .wr_en(stk_we), .wr_addr(stk_waddr), .wr_data(stk_wdata),
      .rd_addr(stk_raddr), .rd_data(stk_rdata));

   cmd_type req_cmd;
   logic [31:0] req_value;
   addr_type req_index;
   logic req_fire, rsp_free;
   logic signed [31:0] rdat;
   addr_type mid, swap_l;
   logic [AddrWidth:0] left_size, right_size;

   assign req_cmd   = cmd_type'(req_tdata[1:0]);
   assign req_value = req_tdata[33:2];
   assign req_index = req_tdata[43:34];
   assign rsp_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE) && !rd_pending_ff && rsp_free;
   assign req_fire  = req_tvalid && req_tready;
   assign rdat      = mem_rdata;
   assign mid = lo_ff + AddrWidth'((hi_ff - lo_ff) >> 1);
   assign left_size  = {1'b0, l_ff} - {1'b0, lo_ff} + 1'b1;
   assign right_size = {1'b0, hi_ff} - {1'b0, l_ff};
   assign swap_l = l_ff;

   // sequencer and command decode
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      sp_in = sp_ff;
      lo_in = lo_ff; hi_in = hi_ff; f_in = f_ff; l_in = l_ff;
      pivot_in = pivot_ff; fval_in = fval_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      rd_pending_in = 1'b0;
      mem_we = 1'b0; mem_waddr = f_ff; mem_wdata = req_value; mem_raddr = f_ff;
      stk_we = 1'b0; stk_waddr = sp_ff; stk_wdata = {lo_ff, l_ff};
      stk_raddr = sp_ff - 1'b1;

      // read data returns in the cycle after the address
      if (rd_pending_ff) begin
         rsp_valid_in = 1'b1;
         rsp_data_in = mem_rdata;
         rsp_status_in = ST_OK;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               rsp_data_in = '0;
               rsp_status_in = ST_OK;
               rsp_valid_in = 1'b1;
               case (req_cmd)
                  CMD_LOAD: begin
                     if (count_ff >= CountWidth'(Capacity)) begin
                        rsp_status_in = ST_FULL;
                     end else begin
                        mem_we = 1'b1;
                        mem_waddr = count_ff[AddrWidth-1:0];
                        count_in = count_ff + 1'b1;
                     end
                  end
                  CMD_READ: begin
                     if ({1'b0, req_index} >= count_ff) begin
                        rsp_status_in = ST_OOR;
                     end else begin
                        mem_raddr = req_index;
                        rsp_valid_in = 1'b0;
                        rd_pending_in = 1'b1;
                     end
                  end
                  CMD_SORT: begin
                     if (count_ff >= CountWidth'(2)) begin
                        rsp_valid_in = 1'b0;
                        lo_in = '0;
                        hi_in = AddrWidth'(count_ff - 1'b1);
                        sp_in = '0;
                        state_in = S_PIVRD;
                     end
                  end
                  CMD_CLEAR: count_in = '0;
                  default: ;
               endcase
            end
         end
         S_PIVRD: begin
            mem_raddr = mid;
            f_in = lo_ff;
            l_in = hi_ff;
            state_in = S_PIVWT;
         end
         S_PIVWT: begin
            pivot_in = rdat;
            state_in = S_FRD;
         end
         S_FRD: begin
            mem_raddr = f_ff;
            state_in = S_FCHK;
         end
         S_FCHK: begin
            // forward scan stops at a value not below the pivot
            if (rdat < pivot_ff) begin
               f_in = f_ff + 1'b1;
               state_in = S_FRD;
               mem_raddr = f_ff + 1'b1;
            end else begin
               fval_in = rdat;
               state_in = S_LRD;
            end
         end
         S_LRD: begin
            mem_raddr = l_ff;
            state_in = S_LCHK;
         end
         S_LCHK: begin
            if (rdat > pivot_ff) begin
               l_in = l_ff - 1'b1;
               state_in = S_LRD;
            end else if (f_ff >= l_ff) begin
               state_in = S_SPLIT;
            end else begin
               // first half of the swap: element at f goes to l
               mem_we = 1'b1;
               mem_waddr = l_ff;
               mem_wdata = fval_ff;
               fval_in = rdat;
               state_in = S_SWAP;
            end
         end
         S_SWAP: begin
            mem_we = 1'b1;
            mem_waddr = f_ff;
            mem_wdata = fval_ff;
            f_in = f_ff + 1'b1;
            l_in = swap_l - 1'b1;
            state_in = S_FRD;
         end
         S_SPLIT: begin
            // push the larger part, carry on with the smaller one
            stk_we = 1'b1;
            sp_in = sp_ff + 1'b1;
            if (left_size >= right_size) begin
               stk_wdata = {lo_ff, l_ff};
               lo_in = l_ff + 1'b1;
               if (l_ff + 1'b1 < hi_ff) state_in = S_PIVRD;
               else state_in = S_POPRD;
               if (l_ff + 1'b1 < hi_ff) lo_in = l_ff + 1'b1;
            end else begin
               stk_wdata = {AddrWidth'(l_ff + 1'b1), hi_ff};
               hi_in = l_ff;
               if (lo_ff < l_ff) state_in = S_PIVRD;
               else state_in = S_POPRD;
            end
         end
         S_POPRD: begin
            if (sp_ff == '0) begin
               state_in = S_IDLE;
               rsp_valid_in = 1'b1;
               rsp_data_in = '0;
               rsp_status_in = ST_OK;
            end else begin
               stk_raddr = sp_ff - 1'b1;
               sp_in = sp_ff - 1'b1;
               state_in = S_POPWT;
            end
         end
         S_POPWT: begin
            lo_in = stk_rdata[2*AddrWidth-1:AddrWidth];
            hi_in = stk_rdata[AddrWidth-1:0];
            if (stk_rdata[2*AddrWidth-1:AddrWidth] < stk_rdata[AddrWidth-1:0])
               state_in = S_PIVRD;
            else
               state_in = S_POPRD;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         sp_ff <= '0;
         rsp_valid_ff <= 1'b0;
         rd_pending_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         sp_ff <= sp_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_pending_ff <= rd_pending_in;
      end
      lo_ff <= lo_in; hi_ff <= hi_in; f_ff <= f_in; l_ff <= l_in;
      pivot_ff <= pivot_in; fval_ff <= fval_in;
      rsp_data_ff <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, count_ff, rsp_status_ff, rsp_data_ff};

   // the range stack never overflows
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SPLIT |-> sp_ff != '1)
      else $error("range stack overflow");
   // a held result is never overwritten
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result lost");
   // the input is shut during a sort
   assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> !req_tready)
      else $error("input open during sort");
   // count never exceeds capacity
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountWidth'(Capacity))
      else $error("count overflow");
endmodule

@@ design/hqs_ram.sv @@
module hqs_ram #(
   parameter int Width = 32,
   parameter int Depth = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   // single write port, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule

@@ bench/hoare_quicksort_engine_tb.sv @@
`timescale 1ns / 100ps

module hoare_quicksort_engine_tb;
   import hqs_pkg::*;

   typedef struct packed {
      logic [31:0] data;
      status_type  status;
      logic [10:0] count;
   } answer_type;

   typedef struct packed {
      cmd_type     cmd;
      logic [31:0] value;
      logic [9:0]  index;
   } command_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [47:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [47:0] rsp_tdata;

   hoare_quicksort_engine uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // mirror of the sorting store
   logic signed [31:0] mirror_store [Capacity];
   int unsigned        mirror_count = 0;

   command_type pending_cmds [$];
   answer_type  awaited_answers [$];
   int          mismatch_count = 0;
   int          sender_idle_pct;
   int          receiver_idle_pct;
   longint      cycle_count = 0;
   logic        req_tready_seen;

   localparam longint CycleLimit = 20_000_000;

   // clock generation
   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // quicksort of the mirror: hoare partition, middle pivot
   function automatic void sort_mirror();
      int lo_stack [$];
      int hi_stack [$];
      int lo, hi, f, l, p;
      logic signed [31:0] pivot, t;
      if (mirror_count < 2) return;
      lo_stack.push_back(0);
      hi_stack.push_back(mirror_count - 1);
      while (lo_stack.size() > 0) begin
         lo = lo_stack.pop_back();
         hi = hi_stack.pop_back();
         if (lo >= hi) continue;
         pivot = mirror_store[lo + (hi - lo) / 2];
         f = lo;
         l = hi;
         forever begin
            while (mirror_store[f] < pivot) f++;
            while (mirror_store[l] > pivot) l--;
            if (f >= l) break;
            t = mirror_store[f];
            mirror_store[f] = mirror_store[l];
            mirror_store[l] = t;
            f++;
            l--;
         end
         p = l;
         lo_stack.push_back(lo);
         hi_stack.push_back(p);
         lo_stack.push_back(p + 1);
         hi_stack.push_back(hi);
      end
   endfunction

   // expected answer for one accepted command
   function automatic answer_type predict_answer(command_type c);
      answer_type a;
      a.data = '0;
      a.status = ST_OK;
      case (c.cmd)
         CMD_LOAD: begin
            if (mirror_count >= Capacity) a.status = ST_FULL;
            else begin
               mirror_store[mirror_count] = c.value;
               mirror_count++;
            end
         end
         CMD_SORT: sort_mirror();
         CMD_READ: begin
            if (c.index >= mirror_count) a.status = ST_OOR;
            else a.data = mirror_store[c.index];
         end
         default: mirror_count = 0;
      endcase
      a.count = mirror_count[10:0];
      return a;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch on %s: got %h, expected %h", what, got, want);
      mismatch_count++;
   endtask

   function automatic void add_cmd(cmd_type op, logic [31:0] v, logic [9:0] idx);
      command_type c;
      c.cmd = op;
      c.value = v;
      c.index = idx;
      pending_cmds.push_back(c);
   endfunction

   function automatic logic [31:0] random_value();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return $urandom_range(0, 7) - 3;
         default: return $urandom;
      endcase
   endfunction

   // driver: present commands at the falling edge
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
      end else if (!req_tvalid || req_tready_seen) begin
         if (pending_cmds.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
            req_tdata  <= {4'b0, pending_cmds[0].index, pending_cmds[0].value,
                           pending_cmds[0].cmd};
            req_tvalid <= 1'b1;
            void'(pending_cmds.pop_front());
         end else begin
            req_tvalid <= 1'b0;
         end
      end
      rsp_tready <= ($urandom_range(0, 99) >= receiver_idle_pct);
   end

   // acceptance of the command seen at the last rising edge
   always @(posedge clock) begin
      if (reset) begin
         req_tready_seen <= 1'b0;
      end else begin
         req_tready_seen <= req_tvalid && req_tready;
         if (req_tvalid && req_tready)
            awaited_answers.push_back(predict_answer(command_type'({req_tdata[1:0],
               req_tdata[33:2], req_tdata[43:34]})));
      end
   end

   // monitor: compare each result transaction with the oldest expectation
   always @(posedge clock) begin
      answer_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = answer_type'({rsp_tdata[31:0], rsp_tdata[33:32], rsp_tdata[44:34]});
         if (awaited_answers.size() == 0) begin
            report_mismatch("unexpected result", rsp_tdata[31:0], 32'h0);
         end else begin
            want = awaited_answers.pop_front();
            if (got.data !== want.data) report_mismatch("data", got.data, want.data);
            if (got.status !== want.status)
               report_mismatch("status", got.status, want.status);
            if (got.count !== want.count) report_mismatch("count", got.count, want.count);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      int n;
      reset = 1'b1;
      sender_idle_pct = 24;
      receiver_idle_pct = 76;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: empty store, extremes, duplicates, out-of-range reads
      add_cmd(CMD_SORT, 32'h0, 10'h0);
      add_cmd(CMD_READ, 32'h0, 10'h0);
      add_cmd(CMD_LOAD, 32'h7fff_ffff, 10'h3ff);
      add_cmd(CMD_SORT, 32'hffff_ffff, 10'h0);
      add_cmd(CMD_LOAD, 32'h8000_0000, 10'h0);
      add_cmd(CMD_LOAD, 32'h0, 10'h0);
      add_cmd(CMD_LOAD, 32'h0, 10'h0);
      add_cmd(CMD_LOAD, 32'hffff_ffff, 10'h0);
      add_cmd(CMD_SORT, 32'h0, 10'h0);
      for (int i = 0; i < 6; i++) add_cmd(CMD_READ, 32'h0, i[9:0]);
      add_cmd(CMD_READ, 32'h0, 10'h3ff);
      add_cmd(CMD_CLEAR, 32'h0, 10'h0);
      add_cmd(CMD_READ, 32'h0, 10'h0);

      // random: load a batch, usually sort, read back, sometimes clear
      for (int ph = 0; ph < 3; ph++) begin
         while (pending_cmds.size() > 0 || awaited_answers.size() > 0 || req_tvalid)
            @(posedge clock);
         sender_idle_pct = (ph == 0) ? 24 : (ph == 1) ? 76 : 0;
         receiver_idle_pct = (ph == 0) ? 76 : (ph == 1) ? 24 : 0;
         for (int b = 0; b < 7; b++) begin
            n = $urandom_range(0, 20);
            repeat (n) add_cmd(CMD_LOAD, random_value(), 10'($urandom));
            if ($urandom_range(0, 7) != 0) add_cmd(CMD_SORT, $urandom, 10'($urandom));
            repeat ($urandom_range(2, 12))
               add_cmd(CMD_READ, $urandom, 10'($urandom_range(0, 40)));
            if ($urandom_range(0, 2) == 0) add_cmd(CMD_CLEAR, $urandom, 10'($urandom));
         end
      end

      while (pending_cmds.size() > 0 || awaited_answers.size() > 0 || req_tvalid)
         @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end
endmodule
